/* rtl/core/grst_pkg.sv */
// Package for the granule range set table.
// Holds the shared constants and command codes; no dependencies.
`timescale 1ns / 1ps
package grst_pkg;
    localparam int TABLE_DEPTH_DEF = 16;
    localparam int GRANULE_BITS_DEF = 24;
    localparam logic [24:0] POP_LIMIT_RESET = 25'd16;
    localparam logic [1:0] CMD_REGISTER = 2'd0;
    localparam logic [1:0] CMD_REMOVE   = 2'd1;
    localparam logic [1:0] CMD_POP      = 2'd2;
    localparam logic [1:0] CMD_CLEAR    = 2'd3;
endpackage

/* rtl/core/grst_mem.sv */
// Entry memory of the granule range set table: start and length per entry.
// Synchronous write, registered read; uses grst_pkg.
`timescale 1ns / 1ps
module grst_mem
    import grst_pkg::*;
#(
    parameter int DEPTH = TABLE_DEPTH_DEF,
    parameter int GB = GRANULE_BITS_DEF,
    localparam int AW = $clog2(DEPTH)
)
(
    input  logic          clk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [GB-1:0] wstart,
    input  logic [GB:0]   wlen,
    input  logic [AW-1:0] raddr,
    output logic [GB-1:0] rstart,
    output logic [GB:0]   rlen
);
    logic [GB-1:0] start_mem [DEPTH];
    logic [GB:0]   len_mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            start_mem[waddr] <= wstart;
            len_mem[waddr] <= wlen;
        end
        rstart <= start_mem[raddr];
        rlen <= len_mem[raddr];
    end
endmodule

/* rtl/core/granule_range_set_table.sv */
// Top level of the granule range set table: APB register, sequencer, memory.
// Depends on grst_pkg and grst_mem.
`timescale 1ns / 1ps
// The block keeps up to TABLE_DEPTH disjoint granule ranges and takes one
// command item at a time on the input channel (command, range_start,
// range_length). Every item yields exactly one result item on the output
// channel: the popped range for a pop, a drop status, the pending total and
// an empty flag. The ranges live in a one-port-read synchronous memory;
// valid bits are flip-flops. A register or remove walks every entry with a
// read state and a modify/write state, then passes a finishing state, in
// which a register writes its merged range. A pop walks the entries once
// to find the lowest start, rereads that entry in the finishing state and
// then trims it in a further state. Clear, and a register or remove of
// zero length, go straight to the result. After reset the table is empty,
// the total is zero and pop_limit is 16. The result waits in an output
// register while the receiver stalls, and no new item is taken until it
// has been delivered. pop_limit sits at address 0 of the APB port and is
// to be written only while the block is idle; the block itself does not
// enforce this, so the user is bound to it.
module granule_range_set_table
    import grst_pkg::*;
#(
    parameter int TABLE_DEPTH = TABLE_DEPTH_DEF,
    localparam int GB = GRANULE_BITS_DEF,
    localparam int AW = $clog2(TABLE_DEPTH)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          psel,
    input  logic          penable,
    input  logic          pwrite,
    input  logic [2:0]    paddr,
    input  logic [31:0]   pwdata,
    output logic [31:0]   prdata,
    output logic          pready,
    input  logic          in_valid,
    output logic          in_ready,
    input  logic [1:0]    command,
    input  logic [GB-1:0] range_start,
    input  logic [GB:0]   range_length,
    output logic          result_valid,
    input  logic          out_ready,
    output logic [GB-1:0] out_start,
    output logic [GB:0]   out_length,
    output logic          out_valid,
    output logic          status,
    output logic [GB:0]   pending_total,
    output logic          table_empty
);
    typedef enum logic [2:0] {S_IDLE, S_READ, S_MOD, S_FIN, S_POPW, S_OUT} state_t;

    state_t          state_reg;
    logic [24:0]     pop_limit_reg;
    logic [TABLE_DEPTH-1:0] valid_reg;
    logic [GB:0]     pend_reg;
    logic [1:0]      cmd_reg;
    logic [GB:0]     s_reg, e_reg;       // GB+1 bits: end may equal 2^GB
    logic [GB:0]     ns_reg, ne_reg;
    logic            slot_hit_reg;
    logic [AW-1:0]   slot_reg;
    logic [AW:0]     idx_reg;
    logic            best_hit_reg;
    logic [AW-1:0]   best_reg;
    logic [GB-1:0]   best_start_reg;
    logic            status_reg;
    logic [GB-1:0]   ostart_reg;
    logic [GB:0]     olen_reg;
    logic            ovalid_reg;

    logic            we;
    logic [AW-1:0]   waddr, raddr;
    logic [GB-1:0]   wstart, rstart, mem_rstart;
    logic [GB:0]     wlen, rlen, mem_rlen;

    // Split pieces are written in a second write through the same port: the
    // trailing piece of a split is held and written in the following cycle, a
    // read or the finishing state of a remove, which never writes otherwise.
    logic          split_pend_reg;
    logic [AW-1:0] split_addr_reg;
    logic [GB-1:0] split_start_reg;
    logic [GB:0]   split_len_reg;
    logic          fwd_hit_reg;

    logic          we_all;
    logic [AW-1:0] waddr_all;
    logic [GB-1:0] wstart_all;
    logic [GB:0]   wlen_all;

    grst_mem #(.DEPTH(TABLE_DEPTH), .GB(GB)) u_mem (
        .clk(clk), .we(we_all), .waddr(waddr_all), .wstart(wstart_all),
        .wlen(wlen_all), .raddr(raddr), .rstart(mem_rstart), .rlen(mem_rlen)
    );

    // When the split piece is written in the same cycle that its entry is
    // read, the read returns old contents, so the piece is forwarded.
    assign rstart = fwd_hit_reg ? split_start_reg : mem_rstart;
    assign rlen = fwd_hit_reg ? split_len_reg : mem_rlen;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == 1'b0) ? {7'd0, pop_limit_reg} : 32'd0;
    assign in_ready = (state_reg == S_IDLE);
    assign result_valid = (state_reg == S_OUT);
    assign out_start = ostart_reg;
    assign out_length = olen_reg;
    assign out_valid = ovalid_reg;
    assign status = status_reg;
    assign pending_total = pend_reg;
    assign table_empty = ~(|valid_reg);

    // Current entry of the walk.
    logic [AW-1:0] cur;
    logic [GB:0]   es, ee;
    assign cur = idx_reg[AW-1:0];
    assign raddr = idx_reg[AW-1:0];
    assign es = {1'b0, rstart};
    assign ee = {1'b0, rstart} + rlen;

    // First free entry: the lowest index whose valid bit is clear.
    logic          free_hit;
    logic [AW-1:0] free_idx;
    always_comb
    begin
        free_hit = 1'b0;
        free_idx = '0;
        for (int i = TABLE_DEPTH - 1; i >= 0; i--)
        begin
            if (!valid_reg[i])
            begin
                free_hit = 1'b1;
                free_idx = AW'(i);
            end
        end
    end

    logic [GB:0] lim;
    assign lim = (pop_limit_reg == 25'd0) ? (GB+1)'(1) : (GB+1)'(pop_limit_reg);

    // Memory write port: remove trims, the merged range of a register and the trimmed pop entry.
    always_comb
    begin
        we = 1'b0;
        waddr = cur;
        wstart = rstart;
        wlen = rlen;
        if (state_reg == S_MOD && valid_reg[cur] && cmd_reg == CMD_REMOVE
            && !(es >= e_reg || ee <= s_reg))
        begin
            if (es < s_reg)
            begin
                we = 1'b1;
                wlen = s_reg - es;
            end
            else if (ee > e_reg)
            begin
                we = 1'b1;
                wstart = e_reg[GB-1:0];
                wlen = ee - e_reg;
            end
        end
        else if (state_reg == S_FIN && cmd_reg == CMD_REGISTER
                 && (slot_hit_reg || free_hit))
        begin
            we = 1'b1;
            waddr = slot_hit_reg ? slot_reg : free_idx;
            wstart = ns_reg[GB-1:0];
            wlen = ne_reg - ns_reg;
        end
        else if (state_reg == S_POPW && best_hit_reg && rlen > lim)
        begin
            we = 1'b1;
            waddr = best_reg;
            wstart = rstart + lim[GB-1:0];
            wlen = rlen - lim;
        end
    end

    // Final best index for the pop read, including the last entry's compare.
    function automatic logic [AW-1:0] best_reg_sel(input logic [1:0] c,
        input logic hit, input logic take, input logic [AW-1:0] b,
        input logic [AW-1:0] k);
        if (c == CMD_POP && take)
            return k;
        return hit ? b : k;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            pop_limit_reg <= POP_LIMIT_RESET;
            valid_reg <= '0;
            pend_reg <= '0;
            split_pend_reg <= 1'b0;
            fwd_hit_reg <= 1'b0;
        end
        else
        begin
            if (psel && penable && pwrite && paddr[2] == 1'b0)
            begin
                pop_limit_reg <= pwdata[24:0];
            end
            split_pend_reg <= 1'b0;
            fwd_hit_reg <= split_pend_reg && (split_addr_reg == raddr);
            case (state_reg)
                S_IDLE:
                begin
                    if (in_valid)
                    begin
                        logic [GB+1:0] e_full;
                        e_full = {2'b00, range_start} + {1'b0, range_length};
                        cmd_reg <= command;
                        s_reg <= {1'b0, range_start};
                        e_reg <= (e_full > (GB+2)'(1 << GB)) ? (GB+1)'(1 << GB)
                                                             : e_full[GB:0];
                        ns_reg <= {1'b0, range_start};
                        ne_reg <= (e_full > (GB+2)'(1 << GB)) ? (GB+1)'(1 << GB)
                                                              : e_full[GB:0];
                        idx_reg <= '0;
                        slot_hit_reg <= 1'b0;
                        best_hit_reg <= 1'b0;
                        status_reg <= 1'b0;
                        ostart_reg <= '0;
                        olen_reg <= '0;
                        ovalid_reg <= 1'b0;
                        if (command == CMD_CLEAR)
                        begin
                            valid_reg <= '0;
                            pend_reg <= '0;
                            state_reg <= S_OUT;
                        end
                        else if (command != CMD_POP && range_length == '0)
                        begin
                            state_reg <= S_OUT;
                        end
                        else
                        begin
                            state_reg <= S_READ;
                        end
                    end
                end
                S_READ:
                begin
                    state_reg <= S_MOD;
                end
                S_MOD:
                begin
                    if (valid_reg[cur])
                    begin
                        case (cmd_reg)
                            CMD_REGISTER:
                            begin
                                if (es <= e_reg && ee >= s_reg)
                                begin
                                    if (es < ns_reg) ns_reg <= es;
                                    if (ee > ne_reg) ne_reg <= ee;
                                    pend_reg <= pend_reg - rlen;
                                    valid_reg[cur] <= 1'b0;
                                    if (!slot_hit_reg)
                                    begin
                                        slot_hit_reg <= 1'b1;
                                        slot_reg <= cur;
                                    end
                                end
                            end
                            CMD_REMOVE:
                            begin
                                if (!(es >= e_reg || ee <= s_reg))
                                begin
                                    if (es < s_reg && ee > e_reg)
                                    begin
                                        if (free_hit)
                                        begin
                                            valid_reg[free_idx] <= 1'b1;
                                            split_pend_reg <= 1'b1;
                                            split_addr_reg <= free_idx;
                                            split_start_reg <= e_reg[GB-1:0];
                                            split_len_reg <= ee - e_reg;
                                            pend_reg <= pend_reg - rlen
                                                        + (s_reg - es) + (ee - e_reg);
                                        end
                                        else
                                        begin
                                            status_reg <= 1'b1;
                                            pend_reg <= pend_reg - rlen + (s_reg - es);
                                        end
                                    end
                                    else if (es < s_reg)
                                        pend_reg <= pend_reg - rlen + (s_reg - es);
                                    else if (ee > e_reg)
                                        pend_reg <= pend_reg - rlen + (ee - e_reg);
                                    else
                                    begin
                                        pend_reg <= pend_reg - rlen;
                                        valid_reg[cur] <= 1'b0;
                                    end
                                end
                            end
                            default:
                            begin
                                if (!best_hit_reg || rstart < best_start_reg)
                                begin
                                    best_hit_reg <= 1'b1;
                                    best_reg <= cur;
                                    best_start_reg <= rstart;
                                end
                            end
                        endcase
                    end
                    if (idx_reg == (AW+1)'(TABLE_DEPTH - 1))
                    begin
                        state_reg <= S_FIN;
                        idx_reg <= {1'b0, best_reg_sel(cmd_reg, best_hit_reg,
                                    valid_reg[cur] && (!best_hit_reg
                                    || rstart < best_start_reg), best_reg, cur)};
                    end
                    else
                    begin
                        idx_reg <= idx_reg + 1'b1;
                        state_reg <= S_READ;
                    end
                end
                S_FIN:
                begin
                    // For a pop the best entry is read here; for a register
                    // the merged range is written.
                    if (cmd_reg == CMD_REGISTER)
                    begin
                        if (slot_hit_reg || free_hit)
                        begin
                            valid_reg[slot_hit_reg ? slot_reg : free_idx] <= 1'b1;
                            pend_reg <= pend_reg + (ne_reg - ns_reg);
                        end
                        else
                            status_reg <= 1'b1;
                        state_reg <= S_OUT;
                    end
                    else if (cmd_reg == CMD_POP)
                        state_reg <= S_POPW;
                    else
                        state_reg <= S_OUT;
                end
                S_POPW:
                begin
                    if (best_hit_reg)
                    begin
                        ostart_reg <= rstart;
                        ovalid_reg <= 1'b1;
                        if (rlen > lim)
                        begin
                            olen_reg <= lim;
                            pend_reg <= pend_reg - lim;
                        end
                        else
                        begin
                            olen_reg <= rlen;
                            pend_reg <= pend_reg - rlen;
                            valid_reg[best_reg] <= 1'b0;
                        end
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_ready)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    // A pending split piece goes out in the cycle that follows its modify state.
    assign we_all = we | split_pend_reg;
    assign waddr_all = split_pend_reg ? split_addr_reg : waddr;
    assign wstart_all = split_pend_reg ? split_start_reg : wstart;
    assign wlen_all = split_pend_reg ? split_len_reg : wlen;
endmodule
